FILE: rtl/pta_pkg.sv
// shared constants, types and helper functions for the partial trace accumulator
package pta_pkg;

  localparam int MAX_FULL_DIM = 64;
  localparam int VAL_W        = 32;
  localparam int DIM_W        = 7;
  localparam int POS_W        = $clog2(MAX_FULL_DIM);
  localparam int STORE_DEPTH  = MAX_FULL_DIM * MAX_FULL_DIM;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int IDX_W        = 12;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // command codes
  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_DIM_BEFORE = 2'd0;
  localparam logic [1:0] REG_DIM_TRACED = 2'd1;
  localparam logic [1:0] REG_DIM_AFTER  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL1  = 5'b00010,
    S_MUL2  = 5'b00100,
    S_WALK  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  // mixed-radix view of a full index plus its reduced sub-index
  typedef struct packed {
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] i;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] red;
  } pos_t;

  typedef struct packed {
    logic             sat;
    logic [VAL_W-1:0] re;
    logic [VAL_W-1:0] im;
  } entry_t;

  // advance a position by one, keeping red = k + j*db
  function automatic pos_t pos_step(pos_t p, logic [DIM_W-1:0] db,
                                    logic [DIM_W-1:0] dt, logic [DIM_W-1:0] da);
    pos_t             q;
    logic [DIM_W-1:0] k1;
    logic [DIM_W-1:0] i1;
    logic [DIM_W-1:0] j1;
    q  = p;
    k1 = DIM_W'(p.k) + DIM_W'(1);
    i1 = DIM_W'(p.i) + DIM_W'(1);
    j1 = DIM_W'(p.j) + DIM_W'(1);
    if (k1 != db) begin
      q.k   = k1[POS_W-1:0];
      q.red = p.red + POS_W'(1);
    end else begin
      q.k = '0;
      if (i1 != dt) begin
        q.i   = i1[POS_W-1:0];
        q.red = p.red - db[POS_W-1:0] + POS_W'(1);
      end else begin
        q.i = '0;
        if (j1 != da) begin
          q.j   = j1[POS_W-1:0];
          q.red = p.red + POS_W'(1);
        end else begin
          q.j   = '0;
          q.red = '0;
        end
      end
    end
    return q;
  endfunction

  // saturating signed add, msb of the result is the overflow flag
  function automatic logic [VAL_W:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W:0] sum;
    logic [VAL_W:0] res;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      res = {1'b1, sum[VAL_W], {(VAL_W-1){~sum[VAL_W]}}};
    end else begin
      res = {1'b0, sum[VAL_W-1:0]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/partial_trace_accumulator_core.sv
// partial trace accumulator: counters, reduced-matrix store and read-modify-write pipeline
//
// a read transaction's result is registered by the store read port, then by the output register or skid slot
// throughput: one transaction per cycle, each accumulate being one store read-modify-write;
// a transaction right behind two reads in a row is stalled, so reads run at two in three at best
// a clear sweeps the 4096-entry store one entry a cycle when the write port is free; inputs stall
// a register write stalls inputs while sizes are rederived and the row and column indexes rebuilt
// reset: synchronous, active high; runs the same clearing sweep of the 4096-entry store
module partial_trace_accumulator_core
  import pta_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [VAL_W-1:0]    elem_real,
  input  logic [VAL_W-1:0]    elem_imag,
  input  logic [IDX_W-1:0]    read_index,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VAL_W-1:0]    out_real,
  output logic [VAL_W-1:0]    out_imag,
  output logic                saturated,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration registers and derived sizes
  logic [DIM_W-1:0]     dim_before;
  logic [DIM_W-1:0]     dim_traced;
  logic [DIM_W-1:0]     dim_after;
  logic [2*DIM_W-1:0]   prod_bt;      // dim_before * dim_traced
  logic [2*DIM_W-1:0]   red_full;     // dim_before * dim_after
  logic [POS_W:0]       full;         // side of the full matrix
  logic [POS_W:0]       red_side;     // side of the reduced matrix
  logic                 cfg_ok;
  logic                 cfg_dirty;
  logic [3*DIM_W-1:0]   prod_all;

  // control
  state_t               state;
  logic [ADDR_W-1:0]    clr_addr;
  logic [POS_W-1:0]     walk_cnt;
  logic [POS_W-1:0]     row_position;
  logic [POS_W-1:0]     col_position;
  logic                 input_done;
  pos_t                 row_d;
  pos_t                 col_d;

  // store and pipeline
  entry_t               mem [STORE_DEPTH];
  entry_t               rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  entry_t               mem_wdata;

  logic                 b_acc;
  logic                 b_read;
  logic [ADDR_W-1:0]    b_idx;
  logic [VAL_W-1:0]     b_re;
  logic [VAL_W-1:0]     b_im;
  logic                 wb_valid;
  logic [ADDR_W-1:0]    wb_idx;
  entry_t               wb_data;
  entry_t               cur;
  entry_t               new_entry;
  logic [VAL_W:0]       add_re;
  logic [VAL_W:0]       add_im;

  logic                 pend_valid;
  entry_t               pend;

  logic                 cfg_wr;
  logic                 in_accept;
  logic                 acc_go;
  logic                 rd_go;
  logic                 clr_go;
  logic                 past_end;
  logic                 acc_hit;
  logic [POS_W:0]       col_inc;
  logic [POS_W:0]       row_inc;
  logic [ADDR_W-1:0]    row_base;
  logic [ADDR_W-1:0]    acc_idx;
  logic                 drain;

  // ---------------------------------------------------------------------------
  // configuration port: writes complete in the access phase, reads are combinational
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_DIM_BEFORE: prdata = PDATA_W'(dim_before);
      REG_DIM_TRACED: prdata = PDATA_W'(dim_traced);
      REG_DIM_AFTER:  prdata = PDATA_W'(dim_after);
      default:        prdata = '0;
    endcase
  end

  assign prod_all = (3*DIM_W)'(prod_bt) * (3*DIM_W)'(dim_after);

  // ---------------------------------------------------------------------------
  // input side: an accumulate is placed by the row/col digit counters; the
  // store index is the reduced column plus reduced side times reduced row
  // ---------------------------------------------------------------------------
  // hold off inputs while busy, while a register write is pending, and while
  // the output register plus its skid slot could overflow
  assign in_stall  = (state != S_IDLE) | cfg_dirty | cfg_wr |
                     (out_valid & (pend_valid | b_read));
  assign in_accept = in_valid & ~in_stall;
  assign acc_go    = in_accept && (cmd == CMD_ACC);
  assign rd_go     = in_accept && (cmd == CMD_READ);
  assign clr_go    = in_accept && (cmd == CMD_CLEAR);

  assign past_end  = ({1'b0, row_position} >= full) || ({1'b0, col_position} >= full);
  assign acc_hit   = acc_go && cfg_ok && !input_done && !past_end && (row_d.i == col_d.i);
  assign col_inc   = {1'b0, col_position} + (POS_W+1)'(1);
  assign row_inc   = {1'b0, row_position} + (POS_W+1)'(1);

  assign row_base  = ADDR_W'(red_side) * ADDR_W'(row_d.red);
  assign acc_idx   = row_base + ADDR_W'(col_d.red);
  assign rd_addr   = (cmd == CMD_READ) ? ADDR_W'(read_index) : acc_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      walk_cnt     <= '0;
      row_position <= '0;
      col_position <= '0;
      input_done   <= 1'b0;
      row_d        <= '0;
      col_d        <= '0;
      dim_before   <= DIM_W'(1);
      dim_traced   <= DIM_W'(2);
      dim_after    <= DIM_W'(1);
      prod_bt      <= (2*DIM_W)'(2);
      red_full     <= (2*DIM_W)'(1);
      full         <= (POS_W+1)'(2);
      red_side     <= (POS_W+1)'(1);
      cfg_ok       <= 1'b1;
      cfg_dirty    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_dirty) begin
            state     <= S_MUL1;
            cfg_dirty <= 1'b0;
          end else if (clr_go) begin
            state        <= S_CLEAR;
            clr_addr     <= '0;
            row_position <= '0;
            col_position <= '0;
            input_done   <= 1'b0;
            row_d        <= '0;
            col_d        <= '0;
          end else if (acc_go && cfg_ok && !input_done) begin
            if (past_end) begin
              // counters stranded beyond a smaller matrix
              input_done <= 1'b1;
            end else begin
              col_d <= pos_step(col_d, dim_before, dim_traced, dim_after);
              if (col_inc >= full) begin
                col_position <= '0;
                row_d        <= pos_step(row_d, dim_before, dim_traced, dim_after);
                if (row_inc >= full) begin
                  row_position <= '0;
                  input_done   <= 1'b1;
                end else begin
                  row_position <= row_inc[POS_W-1:0];
                end
              end else begin
                col_position <= col_inc[POS_W-1:0];
              end
            end
          end
        end
        S_MUL1: begin
          prod_bt  <= (2*DIM_W)'(dim_before) * (2*DIM_W)'(dim_traced);
          red_full <= (2*DIM_W)'(dim_before) * (2*DIM_W)'(dim_after);
          row_d    <= '0;
          col_d    <= '0;
          walk_cnt <= '0;
          state    <= S_MUL2;
        end
        S_MUL2: begin
          cfg_ok   <= (prod_all != '0) && (prod_all <= (3*DIM_W)'(MAX_FULL_DIM));
          full     <= prod_all[POS_W:0];
          red_side <= red_full[POS_W:0];
          state    <= S_WALK;
        end
        S_WALK: begin
          // rebuild the digit counters by stepping from zero up to each position
          if (walk_cnt < row_position) begin
            row_d <= pos_step(row_d, dim_before, dim_traced, dim_after);
          end
          if (walk_cnt < col_position) begin
            col_d <= pos_step(col_d, dim_before, dim_traced, dim_after);
          end
          walk_cnt <= walk_cnt + POS_W'(1);
          if (walk_cnt == POS_W'(MAX_FULL_DIM - 1)) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          // the pipeline write has the port; the sweep waits
          if (!b_acc) begin
            clr_addr <= clr_addr + ADDR_W'(1);
            if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // a register write always forces a rebuild of the derived sizes
      if (cfg_wr) begin
        cfg_dirty <= 1'b1;
        case (paddr[3:2])
          REG_DIM_BEFORE: dim_before <= pwdata[DIM_W-1:0];
          REG_DIM_TRACED: dim_traced <= pwdata[DIM_W-1:0];
          REG_DIM_AFTER:  dim_after  <= pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // store: one write port, one registered read port
  // ---------------------------------------------------------------------------
  assign mem_we    = b_acc | (state == S_CLEAR);
  assign mem_waddr = b_acc ? b_idx : clr_addr;
  assign mem_wdata = b_acc ? new_entry : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // second stage: the read data arrives; forward the previous write when it
  // hit the same entry, since the store read saw the old contents
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_acc    <= 1'b0;
      b_read   <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      b_acc    <= acc_hit;
      b_read   <= rd_go;
      wb_valid <= b_acc;
    end
  end

  always_ff @(posedge clk) begin
    b_idx   <= rd_addr;
    b_re    <= elem_real;
    b_im    <= elem_imag;
    wb_idx  <= b_idx;
    wb_data <= new_entry;
  end

  assign cur       = (wb_valid && (wb_idx == b_idx)) ? wb_data : rd_data;
  assign add_re    = sat_add(cur.re, b_re);
  assign add_im    = sat_add(cur.im, b_im);
  assign new_entry = '{sat: cur.sat | add_re[VAL_W] | add_im[VAL_W],
                       re:  add_re[VAL_W-1:0],
                       im:  add_im[VAL_W-1:0]};

  // ---------------------------------------------------------------------------
  // output register with one skid slot, so inputs keep flowing while a
  // result waits for the consumer
  // ---------------------------------------------------------------------------
  assign drain = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (!out_valid || drain) begin
        out_valid  <= pend_valid | b_read;
        pend_valid <= pend_valid & b_read;
      end else if (b_read) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || drain) begin
      if (pend_valid) begin
        out_real  <= pend.re;
        out_imag  <= pend.im;
        saturated <= pend.sat;
        pend      <= cur;
      end else begin
        out_real  <= cur.re;
        out_imag  <= cur.im;
        saturated <= cur.sat;
      end
    end else if (b_read) begin
      pend <= cur;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("skid slot holds a result while the output register is empty");

  a_one_op_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(b_acc && b_read))
    else $error("accumulate and read in the second stage together");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && !b_acc && (clr_addr == ADDR_W'(STORE_DEPTH - 1)) |=>
    (state == S_IDLE))
    else $error("clearing sweep did not finish after the last entry");

  a_col_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !cfg_dirty && cfg_ok && ({1'b0, col_position} < full) |->
    ({1'b0, col_d.red} < red_side))
    else $error("reduced column index outside the reduced matrix");

endmodule
